// ----- rtl/core/sra_pkg.sv -----
// Shared types, codes and constants of the sector read-ahead prefetcher.
package sra_pkg;

    localparam int SLOTS     = 256;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int ADDR_BITS = 20;
    localparam int COUNT_W   = 8;
    localparam int AHEAD_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int FIELD_SLOT_W = 8;

    localparam logic [COUNT_W-1:0] SAT_COUNT = 8'd255;

    localparam logic signed [ADDR_BITS-1:0] MIN_LBA_RESET = -20'sd150;
    localparam logic signed [ADDR_BITS-1:0] MAX_LBA_RESET = 20'sd449849;
    localparam logic [ADDR_BITS-1:0]        LAST_RESET    = MAX_LBA_RESET + 20'sd1;
    localparam logic [AHEAD_W-1:0]          MAX_AHEAD_RESET     = 6'd16;
    localparam logic [AHEAD_W-1:0]          INITIAL_AHEAD_RESET = 6'd1;
    localparam logic [AHEAD_W-1:0]          BURST_AHEAD_RESET   = 6'd2;

    typedef enum logic [1:0] {
        OP_READ = 2'd0,
        OP_HINT = 2'd1,
        OP_TICK = 2'd2,
        OP_DONE = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LBA       = 3'd0,
        CFG_MAX_LBA       = 3'd1,
        CFG_MAX_AHEAD     = 3'd2,
        CFG_INITIAL_AHEAD = 3'd3,
        CFG_BURST_AHEAD   = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WIN   = 4'b0100,
        ST_ISSUE = 4'b1000
    } state_t;

    typedef struct packed {
        logic [1:0]                  operation;
        logic signed [ADDR_BITS-1:0] sector_addr;
        logic                        fetch_ok;
    } req_t;

    typedef struct packed {
        logic                        fetch_issue;
        logic signed [ADDR_BITS-1:0] fetch_addr;
        logic [FIELD_SLOT_W-1:0]     fetch_slot;
        logic                        hit;
        logic [FIELD_SLOT_W-1:0]     hit_slot;
        logic                        hit_error;
        logic                        out_of_range;
    } res_t;

    typedef struct packed {
        logic                 valid;
        logic                 error;
        logic [ADDR_BITS-1:0] addr;
    } tag_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        tag_t              tag;
    } tag_wr_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              error;
    } scan_res_t;

endpackage

// ----- rtl/core/sra_tag_ram.sv -----
// Ring tag store: address and error in a synchronous memory, valid bits in flops.
module sra_tag_ram (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sra_pkg::tag_wr_t                    wr,
    input  logic                                rd_en,
    input  logic [sra_pkg::SLOT_W-1:0]          rd_slot,
    output sra_pkg::tag_t                       rd_tag
);

    logic [sra_pkg::ADDR_BITS:0]   mem_reg [sra_pkg::SLOTS];
    logic [sra_pkg::ADDR_BITS:0]   rd_data_reg;
    logic [sra_pkg::SLOTS-1:0]     valid_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.slot] <= {wr.tag.error, wr.tag.addr};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.slot] <= wr.tag.valid;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_slot];
            end
        end
    end

    assign rd_tag.valid = rd_valid_reg;
    assign rd_tag.error = rd_data_reg[sra_pkg::ADDR_BITS];
    assign rd_tag.addr  = rd_data_reg[sra_pkg::ADDR_BITS-1:0];

endmodule

// ----- rtl/core/sra_scan.sv -----
// Tag scan engine: walks every ring slot once and keeps the last valid match.
module sra_scan (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [sra_pkg::ADDR_BITS-1:0]      key,
    output logic                               rd_en,
    output logic [sra_pkg::SLOT_W-1:0]         rd_slot,
    input  sra_pkg::tag_t                      rd_tag,
    output logic                               done,
    output sra_pkg::scan_res_t                 res
);

    logic                              active_reg;
    logic [sra_pkg::SLOT_W-1:0]        idx_reg;
    logic                              pend_reg;
    logic [sra_pkg::SLOT_W-1:0]        pend_idx_reg;
    logic                              pend_last_reg;
    logic [sra_pkg::ADDR_BITS-1:0]     key_reg;
    sra_pkg::scan_res_t                res_reg;
    logic                              done_reg;
    logic                              last_idx;
    logic                              match;

    assign last_idx = (idx_reg == sra_pkg::SLOT_W'(sra_pkg::SLOTS - 1));
    assign match    = pend_reg && rd_tag.valid && (rd_tag.addr == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            pend_last_reg <= 1'b0;
            key_reg       <= '0;
            res_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= pend_reg && pend_last_reg;
            if (start)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
                pend_reg   <= 1'b0;
                key_reg    <= key;
                res_reg    <= '0;
            end
            else
            begin
                pend_reg      <= active_reg;
                pend_idx_reg  <= idx_reg;
                pend_last_reg <= last_idx;
                if (active_reg)
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (last_idx)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                if (match)
                begin
                    res_reg.hit   <= 1'b1;
                    res_reg.slot  <= pend_idx_reg;
                    res_reg.error <= rd_tag.error;
                end
            end
        end
    end

    assign rd_en   = active_reg;
    assign rd_slot = idx_reg;
    assign done    = done_reg;
    assign res     = res_reg;

endmodule

// ----- rtl/core/sra_ctrl.sv -----
// Sequencer: configuration, read-ahead window, fetch issue and result register.
module sra_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  sra_pkg::req_t                      request,
    output logic                               busy,
    output logic                               result_valid,
    output sra_pkg::res_t                      result,
    input  logic                               cfg_valid,
    input  logic [sra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sra_pkg::ADDR_BITS-1:0]      cfg_data,
    output logic                               scan_start,
    output logic [sra_pkg::ADDR_BITS-1:0]      scan_key,
    input  logic                               scan_done,
    input  sra_pkg::scan_res_t                 scan_res,
    output sra_pkg::tag_wr_t                   tag_wr
);

    localparam int DW = sra_pkg::ADDR_BITS + 1;
    localparam int CW = sra_pkg::ADDR_BITS + 2;

    sra_pkg::state_t                       state_reg;
    logic signed [sra_pkg::ADDR_BITS-1:0]  min_lba_reg;
    logic signed [sra_pkg::ADDR_BITS-1:0]  max_lba_reg;
    logic [sra_pkg::AHEAD_W-1:0]           max_ahead_reg;
    logic [sra_pkg::AHEAD_W-1:0]           initial_ahead_reg;
    logic [sra_pkg::AHEAD_W-1:0]           burst_ahead_reg;
    logic [sra_pkg::ADDR_BITS-1:0]         ahead_addr_reg;
    logic [sra_pkg::COUNT_W-1:0]           ahead_count_reg;
    logic [sra_pkg::ADDR_BITS-1:0]         last_req_reg;
    logic [sra_pkg::SLOT_W-1:0]            write_slot_reg;
    logic                                  pending_reg;
    logic [sra_pkg::ADDR_BITS-1:0]         pend_addr_reg;
    logic [1:0]                            op_reg;
    logic [sra_pkg::ADDR_BITS-1:0]         addr_reg;
    logic                                  ok_reg;
    logic                                  oor_reg;
    logic                                  result_valid_reg;
    sra_pkg::res_t                         result_reg;

    logic                                  accept;
    logic                                  addr_op;
    logic                                  oor_now;
    logic                                  sequential;
    logic signed [DW-1:0]                  diff;
    logic                                  near;
    logic signed [CW-1:0]                  cand;
    logic [sra_pkg::COUNT_W-1:0]           count_next;
    logic [sra_pkg::COUNT_W-1:0]           count_eff;
    logic                                  issue;
    logic                                  window_op;
    logic                                  done_op;
    logic                                  report_hit;

    assign accept  = start && (state_reg == sra_pkg::ST_IDLE);
    assign addr_op = (request.operation == sra_pkg::OP_READ)
                  || (request.operation == sra_pkg::OP_HINT);
    assign oor_now = addr_op && ((request.sector_addr < min_lba_reg)
                              || (request.sector_addr > max_lba_reg));

    assign scan_start = accept && (request.operation == sra_pkg::OP_READ) && !oor_now;
    assign scan_key   = request.sector_addr;

    assign window_op  = ((op_reg == sra_pkg::OP_READ) || (op_reg == sra_pkg::OP_HINT))
                     && !oor_reg;
    assign done_op    = (op_reg == sra_pkg::OP_DONE) && pending_reg;
    assign report_hit = (op_reg == sra_pkg::OP_READ) && !oor_reg;

    assign sequential = (addr_reg == last_req_reg + 1'b1);
    assign diff = $signed({ahead_addr_reg[sra_pkg::ADDR_BITS-1], ahead_addr_reg})
                - $signed({addr_reg[sra_pkg::ADDR_BITS-1], addr_reg});
    assign near = diff <= $signed({(DW - sra_pkg::AHEAD_W)'(0), max_ahead_reg});
    assign cand = $signed({(CW - sra_pkg::AHEAD_W)'(0), max_ahead_reg})
                + $signed(CW'(1)) - CW'(diff);

    always_comb
    begin
        if ($signed({(CW - sra_pkg::AHEAD_W)'(0), burst_ahead_reg}) < cand)
        begin
            count_next = sra_pkg::COUNT_W'(burst_ahead_reg);
        end
        else
        begin
            count_next = cand[sra_pkg::COUNT_W-1:0];
        end
    end

    assign count_eff = ((ahead_count_reg != '0) && (ahead_addr_reg == max_lba_reg))
                     ? '0 : ahead_count_reg;
    assign issue     = (count_eff != '0) && !pending_reg;

    always_comb
    begin
        tag_wr = '0;
        unique case (state_reg)
            sra_pkg::ST_WIN:
            begin
                tag_wr.en        = done_op;
                tag_wr.slot      = write_slot_reg;
                tag_wr.tag.valid = 1'b1;
                tag_wr.tag.error = !ok_reg;
                tag_wr.tag.addr  = pend_addr_reg;
            end
            sra_pkg::ST_ISSUE:
            begin
                tag_wr.en        = issue;
                tag_wr.slot      = write_slot_reg;
                tag_wr.tag.valid = 1'b0;
                tag_wr.tag.error = 1'b0;
                tag_wr.tag.addr  = ahead_addr_reg;
            end
            default:
            begin
                tag_wr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_lba_reg       <= sra_pkg::MIN_LBA_RESET;
            max_lba_reg       <= sra_pkg::MAX_LBA_RESET;
            max_ahead_reg     <= sra_pkg::MAX_AHEAD_RESET;
            initial_ahead_reg <= sra_pkg::INITIAL_AHEAD_RESET;
            burst_ahead_reg   <= sra_pkg::BURST_AHEAD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (sra_pkg::cfg_idx_t'(cfg_index))
                sra_pkg::CFG_MIN_LBA:       min_lba_reg       <= cfg_data;
                sra_pkg::CFG_MAX_LBA:       max_lba_reg       <= cfg_data;
                sra_pkg::CFG_MAX_AHEAD:     max_ahead_reg     <= cfg_data[sra_pkg::AHEAD_W-1:0];
                sra_pkg::CFG_INITIAL_AHEAD: initial_ahead_reg <= cfg_data[sra_pkg::AHEAD_W-1:0];
                sra_pkg::CFG_BURST_AHEAD:   burst_ahead_reg   <= cfg_data[sra_pkg::AHEAD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sra_pkg::ST_IDLE;
            ahead_addr_reg   <= '0;
            ahead_count_reg  <= '0;
            last_req_reg     <= sra_pkg::LAST_RESET;
            write_slot_reg   <= '0;
            pending_reg      <= 1'b0;
            pend_addr_reg    <= '0;
            op_reg           <= '0;
            addr_reg         <= '0;
            ok_reg           <= 1'b0;
            oor_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= (state_reg == sra_pkg::ST_ISSUE);
            unique case (state_reg)
                sra_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= request.operation;
                        addr_reg  <= request.sector_addr;
                        ok_reg    <= request.fetch_ok;
                        oor_reg   <= oor_now;
                        state_reg <= scan_start ? sra_pkg::ST_SCAN : sra_pkg::ST_WIN;
                    end
                end
                sra_pkg::ST_SCAN:
                begin
                    if (scan_done)
                    begin
                        state_reg <= sra_pkg::ST_WIN;
                    end
                end
                sra_pkg::ST_WIN:
                begin
                    if (window_op)
                    begin
                        if (sequential)
                        begin
                            if (near)
                            begin
                                ahead_count_reg <= count_next;
                            end
                            else if (ahead_count_reg < sra_pkg::SAT_COUNT)
                            begin
                                ahead_count_reg <= ahead_count_reg + 1'b1;
                            end
                        end
                        else if (addr_reg != last_req_reg)
                        begin
                            ahead_addr_reg  <= addr_reg;
                            ahead_count_reg <= sra_pkg::COUNT_W'(initial_ahead_reg);
                        end
                        last_req_reg <= addr_reg;
                    end
                    if (done_op)
                    begin
                        write_slot_reg <= write_slot_reg + 1'b1;
                        pending_reg    <= 1'b0;
                    end
                    state_reg <= sra_pkg::ST_ISSUE;
                end
                sra_pkg::ST_ISSUE:
                begin
                    ahead_count_reg <= issue ? count_eff - 1'b1 : count_eff;
                    if (issue)
                    begin
                        ahead_addr_reg <= ahead_addr_reg + 1'b1;
                        pending_reg    <= 1'b1;
                        pend_addr_reg  <= ahead_addr_reg;
                    end
                    result_reg.fetch_issue  <= issue;
                    result_reg.fetch_addr   <= issue ? ahead_addr_reg : '0;
                    result_reg.fetch_slot   <= issue
                                             ? sra_pkg::FIELD_SLOT_W'(write_slot_reg) : '0;
                    result_reg.hit          <= report_hit && scan_res.hit;
                    result_reg.hit_slot     <= (report_hit && scan_res.hit)
                                             ? sra_pkg::FIELD_SLOT_W'(scan_res.slot) : '0;
                    result_reg.hit_error    <= report_hit && scan_res.hit && scan_res.error;
                    result_reg.out_of_range <= oor_reg;
                    state_reg               <= sra_pkg::ST_IDLE;
                end
                default:
                begin
                    state_reg <= sra_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != sra_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/core/sector_readahead_prefetcher.sv -----
// Top level of the sector read-ahead prefetcher.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------
//  request   | start / busy              | request (sra_pkg::req_t)
//  result    | result_valid strobe       | result (sra_pkg::res_t)
//  config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// An in-range read request walks all SLOTS tag entries between accept and result:
// the tag memory is scanned one entry per cycle through its single read port.
// Hint, idle tick, fetch done and out-of-range reads skip the scan; the next
// request may be taken in the cycle that the result strobe is high.
// Reset clears all tag valid bits at once; no clearing pass is needed.
// Results cannot be stalled; cfg_ready is always high.
module sector_readahead_prefetcher (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  sra_pkg::req_t                      request,
    output logic                               result_valid,
    output sra_pkg::res_t                      result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sra_pkg::ADDR_BITS-1:0]      cfg_data
);

    logic                              scan_start;
    logic [sra_pkg::ADDR_BITS-1:0]     scan_key;
    logic                              scan_done;
    sra_pkg::scan_res_t                scan_res;
    sra_pkg::tag_wr_t                  tag_wr;
    logic                              rd_en;
    logic [sra_pkg::SLOT_W-1:0]        rd_slot;
    sra_pkg::tag_t                     rd_tag;

    assign cfg_ready = 1'b1;

    sra_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .scan_start   (scan_start),
        .scan_key     (scan_key),
        .scan_done    (scan_done),
        .scan_res     (scan_res),
        .tag_wr       (tag_wr)
    );

    sra_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .key     (scan_key),
        .rd_en   (rd_en),
        .rd_slot (rd_slot),
        .rd_tag  (rd_tag),
        .done    (scan_done),
        .res     (scan_res)
    );

    sra_tag_ram u_tag_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tag_wr),
        .rd_en   (rd_en),
        .rd_slot (rd_slot),
        .rd_tag  (rd_tag)
    );

endmodule

// ----- rtl/core/sra_checker.sv -----
// Port-level checks of the sector read-ahead prefetcher, bound to the top level.
module sra_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            result_valid,
    input sra_pkg::res_t   result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without preceding work");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hit) |-> !result.out_of_range)
        else $error("hit reported for rejected address");

    a_error_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hit_error) |-> result.hit)
        else $error("hit error without hit");

endmodule

bind sector_readahead_prefetcher sra_checker u_sra_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the sector read-ahead prefetcher: directed and random requests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sra_pkg::*;

    typedef struct {
        req_t req;
        bit   fixed;
        res_t want;
    } probe_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    req_t                      request;
    logic                      result_valid;
    res_t                      result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [ADDR_BITS-1:0]      cfg_data;

    logic signed [ADDR_BITS-1:0] lba_lo;
    logic signed [ADDR_BITS-1:0] lba_hi;
    logic [AHEAD_W-1:0]          ahead_max;
    logic [AHEAD_W-1:0]          ahead_init;
    logic [AHEAD_W-1:0]          ahead_burst;
    logic [ADDR_BITS-1:0]        win_addr;
    logic [COUNT_W-1:0]          win_count;
    logic [ADDR_BITS-1:0]        prev_req;
    logic [SLOT_W-1:0]           ring_pos;
    logic                        in_flight;
    tag_t                        tag_ram [SLOTS];

    res_t   outcome_q [$];
    probe_t probe_q [$];
    int     bad_count;
    int     run_left;
    int     cursor;

    sector_readahead_prefetcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic res_t readahead_step(input req_t r);
        res_t                 o;
        logic [ADDR_BITS-1:0] a;
        int                   d;
        int                   span;
        o = '0;
        a = r.sector_addr;
        if (r.operation == OP_READ || r.operation == OP_HINT) begin
            if ($signed(a) < lba_lo || $signed(a) > lba_hi) begin
                o.out_of_range = 1'b1;
            end
            else begin
                if (r.operation == OP_READ) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tag_ram[i].valid && tag_ram[i].addr == a) begin
                            o.hit       = 1'b1;
                            o.hit_slot  = FIELD_SLOT_W'(i);
                            o.hit_error = tag_ram[i].error;
                        end
                    end
                end
                if (a == ADDR_BITS'(prev_req + 1'b1)) begin
                    d = int'($signed(win_addr)) - int'($signed(a));
                    if (d <= int'(ahead_max)) begin
                        span = 1 + int'(ahead_max) - d;
                        if (int'(ahead_burst) < span)
                            win_count = COUNT_W'(ahead_burst);
                        else
                            win_count = COUNT_W'(span);
                    end
                    else if (win_count != SAT_COUNT) begin
                        win_count = win_count + 1'b1;
                    end
                end
                else if (a != prev_req) begin
                    win_addr  = a;
                    win_count = COUNT_W'(ahead_init);
                end
                prev_req = a;
            end
        end
        else if (r.operation == OP_DONE && in_flight) begin
            tag_ram[ring_pos].valid = 1'b1;
            tag_ram[ring_pos].error = !r.fetch_ok;
            ring_pos  = ring_pos + 1'b1;
            in_flight = 1'b0;
        end
        if (win_count != 0 && win_addr == lba_hi)
            win_count = '0;
        if (win_count != 0 && !in_flight) begin
            tag_ram[ring_pos].valid = 1'b0;
            tag_ram[ring_pos].addr  = win_addr;
            in_flight     = 1'b1;
            o.fetch_issue = 1'b1;
            o.fetch_addr  = win_addr;
            o.fetch_slot  = ring_pos;
            win_addr      = win_addr + 1'b1;
            win_count     = win_count - 1'b1;
        end
        return o;
    endfunction

    function automatic res_t outcome(input bit issue, input int faddr, input int fslot,
                                     input bit hit, input int hslot, input bit herr,
                                     input bit oor);
        res_t o;
        o.fetch_issue  = issue;
        o.fetch_addr   = faddr[ADDR_BITS-1:0];
        o.fetch_slot   = fslot[FIELD_SLOT_W-1:0];
        o.hit          = hit;
        o.hit_slot     = hslot[FIELD_SLOT_W-1:0];
        o.hit_error    = herr;
        o.out_of_range = oor;
        return o;
    endfunction

    function automatic int pick_base();
        if (lba_lo <= lba_hi)
            return int'(lba_lo) + int'($urandom_range(0, int'(lba_hi) - int'(lba_lo)));
        return int'($urandom_range(0, 1048575)) - 524288;
    endfunction

    task automatic probe(input op_t op, input int addr, input bit ok, input bit fixed,
                         input res_t want);
        probe_t p;
        p.req.operation   = op;
        p.req.sector_addr = addr[ADDR_BITS-1:0];
        p.req.fetch_ok    = ok;
        p.fixed           = fixed;
        p.want            = want;
        probe_q.push_back(p);
    endtask

    task automatic present(input req_t r, input bit fixed, input res_t want);
        int   gap;
        res_t got;
        if (run_left > 0) begin
            gap = 0;
            run_left--;
        end
        else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0)
                run_left = $urandom_range(5, 30);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        got = readahead_step(r);
        outcome_q.push_back(fixed ? want : got);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[ADDR_BITS-1:0];
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MIN_LBA:       lba_lo      = val[ADDR_BITS-1:0];
            CFG_MAX_LBA:       lba_hi      = val[ADDR_BITS-1:0];
            CFG_MAX_AHEAD:     ahead_max   = val[AHEAD_W-1:0];
            CFG_INITIAL_AHEAD: ahead_init  = val[AHEAD_W-1:0];
            CFG_BURST_AHEAD:   ahead_burst = val[AHEAD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int lo, input int hi, input int ma, input int ia,
                              input int ba);
        write_reg(CFG_MIN_LBA, lo);
        write_reg(CFG_MAX_LBA, hi);
        write_reg(CFG_MAX_AHEAD, ma);
        write_reg(CFG_INITIAL_AHEAD, ia);
        write_reg(CFG_BURST_AHEAD, ba);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_mix(input int n);
        req_t r;
        int   k;
        cursor = pick_base();
        for (int j = 0; j < n; j++) begin
            r          = '0;
            r.fetch_ok = ($urandom_range(0, 7) != 0);
            k          = $urandom_range(0, 99);
            if (k < 45)
                r.operation = OP_DONE;
            else if (k < 80)
                r.operation = OP_READ;
            else if (k < 90)
                r.operation = OP_HINT;
            else
                r.operation = OP_TICK;
            if (r.operation == OP_READ || r.operation == OP_HINT) begin
                k = $urandom_range(0, 99);
                if (k < 55)
                    cursor = cursor + 1;
                else if (k >= 70 && k < 85)
                    cursor = cursor - int'($urandom_range(1, 24));
                else if (k >= 85 && k < 93)
                    cursor = pick_base();
                else if (k >= 93)
                    cursor = $urandom;
                r.sector_addr = cursor[ADDR_BITS-1:0];
                cursor = int'($signed(r.sector_addr));
            end
            else begin
                r.sector_addr = ADDR_BITS'($urandom);
            end
            present(r, 1'b0, '0);
        end
    endtask

    always @(posedge clk) begin
        res_t want;
        if (rst_n && result_valid) begin
            if (outcome_q.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("unexpected result %p", result);
            end
            else begin
                want = outcome_q.pop_front();
                if (result.fetch_issue  !== want.fetch_issue  ||
                    result.fetch_addr   !== want.fetch_addr   ||
                    result.fetch_slot   !== want.fetch_slot   ||
                    result.hit          !== want.hit          ||
                    result.hit_slot     !== want.hit_slot     ||
                    result.hit_error    !== want.hit_error    ||
                    result.out_of_range !== want.out_of_range) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("result mismatch: expected %p got %p", want, result);
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        req_t r;
        int   k;
        int   lo;
        int   hi;
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        bad_count = 0;
        run_left  = 0;

        lba_lo      = MIN_LBA_RESET;
        lba_hi      = MAX_LBA_RESET;
        ahead_max   = MAX_AHEAD_RESET;
        ahead_init  = INITIAL_AHEAD_RESET;
        ahead_burst = BURST_AHEAD_RESET;
        win_addr    = '0;
        win_count   = '0;
        prev_req    = LAST_RESET;
        ring_pos    = '0;
        in_flight   = 1'b0;
        foreach (tag_ram[i])
            tag_ram[i] = '0;

        probe(OP_TICK, 0, 1'b0, 1'b1, '0);
        probe(OP_DONE, 0, 1'b1, 1'b1, '0);
        probe(OP_READ, -524288, 1'b0, 1'b1, outcome(0, 0, 0, 0, 0, 0, 1));
        probe(OP_HINT, 524287, 1'b0, 1'b1, outcome(0, 0, 0, 0, 0, 0, 1));
        probe(OP_READ, 100, 1'b0, 1'b1, outcome(1, 100, 0, 0, 0, 0, 0));
        probe(OP_DONE, 0, 1'b0, 1'b1, '0);
        probe(OP_READ, 100, 1'b0, 1'b1, outcome(0, 0, 0, 1, 0, 1, 0));
        probe(OP_READ, 101, 1'b0, 1'b0, '0);
        probe(OP_DONE, 0, 1'b1, 1'b0, '0);
        probe(OP_DONE, 0, 1'b1, 1'b0, '0);
        probe(OP_READ, 101, 1'b0, 1'b0, '0);
        probe(OP_READ, 102, 1'b0, 1'b0, '0);
        probe(OP_TICK, 0, 1'b0, 1'b0, '0);
        probe(OP_HINT, 5000, 1'b0, 1'b0, '0);
        probe(OP_DONE, 0, 1'b1, 1'b0, '0);
        probe(OP_READ, 5000, 1'b0, 1'b0, '0);
        probe(OP_READ, 449849, 1'b0, 1'b0, '0);
        probe(OP_READ, -150, 1'b0, 1'b0, '0);
        probe(OP_HINT, -151, 1'b0, 1'b1, outcome(0, 0, 0, 0, 0, 0, 1));
        probe(OP_DONE, 0, 1'b0, 1'b0, '0);
        probe(OP_READ, -1, 1'b0, 1'b0, '0);
        probe(OP_HINT, 449850, 1'b1, 1'b1, outcome(0, 0, 0, 0, 0, 0, 1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_q[i])
            present(probe_q[i].req, probe_q[i].fixed, probe_q[i].want);
        run_mix(400);
        settle();

        // run the request address across the top of the range so the window count saturates
        set_config(-524288, 524287, 63, 63, 63);
        r             = '0;
        r.operation   = OP_READ;
        r.sector_addr = 20'sd524280;
        present(r, 1'b0, '0);
        cursor = 524280;
        for (int j = 0; j < 300; j++) begin
            k          = $urandom_range(0, 99);
            r.fetch_ok = 1'($urandom_range(0, 1));
            if (k < 10) begin
                r.operation   = OP_TICK;
                r.sector_addr = ADDR_BITS'($urandom);
            end
            else begin
                r.operation   = (k < 85) ? OP_READ : OP_HINT;
                cursor        = cursor + 1;
                r.sector_addr = cursor[ADDR_BITS-1:0];
            end
            present(r, 1'b0, '0);
        end
        run_mix(100);
        settle();

        set_config(0, 40, 1, 1, 1);
        run_mix(300);
        settle();

        for (int p = 0; p < 2; p++) begin
            lo = int'($urandom_range(0, 1048575)) - 524288;
            hi = int'($urandom_range(0, 1048575)) - 524288;
            if (lo > hi && $urandom_range(0, 3) != 0) begin
                k  = lo;
                lo = hi;
                hi = k;
            end
            set_config(lo, hi, $urandom_range(1, 63), $urandom_range(1, 63),
                       $urandom_range(1, 63));
            run_mix(300);
            settle();
        end

        set_config(524287, -524288, 1, 63, 1);
        run_mix(80);
        settle();

        repeat (300) @(posedge clk);
        if (bad_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/sra_pkg.sv
rtl/core/sra_tag_ram.sv
rtl/core/sra_scan.sv
rtl/core/sra_ctrl.sv
rtl/core/sector_readahead_prefetcher.sv
rtl/core/sra_checker.sv
tb/tb.sv
